// ----- hdl/barrier_factor_eval_top_assert.svh -----
// assertion macros shared by the barrier factor checker
`ifndef BARRIER_FACTOR_EVAL_TOP_ASSERT_SVH
`define BARRIER_FACTOR_EVAL_TOP_ASSERT_SVH

// implication checked on every clock edge outside reset
`define BFE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// invariant checked on every clock edge outside reset
`define BFE_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`endif

// ----- hdl/bfe_pkg.sv -----
// types, constants and arithmetic helpers of the barrier factor pipeline
package bfe_pkg;

   localparam int FRAC_BITS_OUT_DEFAULT = 32;
   localparam int OUT_W = 48;
   localparam int ROOT_W = 48;

   localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
   localparam logic [63:0] C3_Q32 = 64'h0000_0003_0000_0000;
   localparam logic [63:0] C6_Q32 = 64'h0000_0006_0000_0000;
   localparam logic [63:0] C9_Q32 = 64'h0000_0009_0000_0000;
   localparam logic [63:0] C45_Q32 = 64'h0000_002D_0000_0000;
   localparam logic [63:0] C225_Q32 = 64'h0000_00E1_0000_0000;
   localparam logic [47:0] OUT_MASK = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] RADIUS_RESET = 32'd52009370;

   localparam logic [1:0] CSR_SPIN = 2'd0;
   localparam logic [1:0] CSR_RADIUS = 2'd1;
   localparam logic [1:0] CSR_REF_MOMENTUM = 2'd2;

   localparam logic [2:0] SPIN_1 = 3'd1;
   localparam logic [2:0] SPIN_2 = 3'd2;
   localparam logic [2:0] SPIN_3 = 3'd3;

   localparam int LANE_STAGES = 10;
   localparam int DIV_STAGES = 49;
   localparam int SQRT_STAGES = 48;
   localparam int LATENCY = LANE_STAGES + DIV_STAGES + SQRT_STAGES;

   typedef struct packed {
      logic [63:0] ll;
      logic [63:0] lh;
      logic [63:0] hl;
      logic [63:0] hh;
   } pp_type;

   typedef struct packed {
      logic [63:0] value;
      logic        sat;
   } sat_sum_type;

   function automatic pp_type mul_parts(input logic [63:0] a, input logic [63:0] b);
      pp_type p;
      p.ll = 64'(a[31:0]) * 64'(b[31:0]);
      p.lh = 64'(a[31:0]) * 64'(b[63:32]);
      p.hl = 64'(a[63:32]) * 64'(b[31:0]);
      p.hh = 64'(a[63:32]) * 64'(b[63:32]);
      return p;
   endfunction

   function automatic logic [127:0] mul_sum(input pp_type p);
      return {p.hh, 64'b0} + {32'b0, p.lh, 32'b0} + {32'b0, p.hl, 32'b0} + {64'b0, p.ll};
   endfunction

   function automatic sat_sum_type add_sat(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      sat_sum_type r;
      s = {1'b0, a} + {1'b0, b};
      r.sat = s[64];
      r.value = s[64] ? {64{1'b1}} : s[63:0];
      return r;
   endfunction

endpackage

// ----- hdl/bfe_poly_lane.sv -----
// one lane: z from momentum and radius, then the spin polynomial by horner steps
module bfe_poly_lane (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [31:0] momentum,
   input  logic [31:0] radius,
   input  logic [2:0]  spin,
   output logic        out_valid,
   output logic [63:0] poly_value,
   output logic        poly_sat
);

   logic [9:0] valid_ff;
   logic [63:0] pr_ff;
   bfe_pkg::pp_type ppz_ff, pp5_ff, pp8_ff;
   logic [55:0] z3_ff, z4_ff, z5_ff, z6_ff, z7_ff;
   logic [63:0] t4_ff, t5_ff, t6_ff, t7_ff, t8_ff, t9_ff;
   logic [63:0] m6_ff, u7_ff, u8_ff, u9_ff, m9_ff;
   logic sat4_ff, sat5_ff, sat6_ff, sat7_ff, sat8_ff, sat9_ff;
   logic [63:0] f_ff;
   logic sat_ff;

   logic use_lin, use_quad, use_cub;
   logic [63:0] c1, c2;
   logic [127:0] prod3, prod6, prod9;
   bfe_pkg::sat_sum_type add4, add7, add10;
   logic [63:0] f_in;
   logic sat10_in, msat6, msat9;

   always_comb begin
      use_lin = 1'b0;
      use_quad = 1'b0;
      use_cub = 1'b0;
      c1 = bfe_pkg::ONE_Q32;
      c2 = bfe_pkg::C45_Q32;
      case (spin)
         bfe_pkg::SPIN_1: begin
            use_lin = 1'b1;
         end
         bfe_pkg::SPIN_2: begin
            use_lin = 1'b1;
            use_quad = 1'b1;
            c1 = bfe_pkg::C3_Q32;
            c2 = bfe_pkg::C9_Q32;
         end
         bfe_pkg::SPIN_3: begin
            use_lin = 1'b1;
            use_quad = 1'b1;
            use_cub = 1'b1;
            c1 = bfe_pkg::C6_Q32;
         end
         default: begin
            use_lin = 1'b0;
         end
      endcase
   end

   assign prod3 = bfe_pkg::mul_sum(ppz_ff);
   assign add4 = bfe_pkg::add_sat({8'b0, z3_ff}, c1);
   assign prod6 = bfe_pkg::mul_sum(pp5_ff);
   assign msat6 = |prod6[127:96];
   assign add7 = bfe_pkg::add_sat(m6_ff, c2);
   assign prod9 = bfe_pkg::mul_sum(pp8_ff);
   assign msat9 = |prod9[127:96];
   assign add10 = bfe_pkg::add_sat(m9_ff, bfe_pkg::C225_Q32);

   always_comb begin
      sat10_in = sat9_ff | (use_cub & add10.sat);
      case (spin)
         bfe_pkg::SPIN_1: f_in = t9_ff;
         bfe_pkg::SPIN_2: f_in = u9_ff;
         bfe_pkg::SPIN_3: f_in = add10.value;
         default: f_in = bfe_pkg::ONE_Q32;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[8:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      pr_ff <= 64'(momentum) * 64'(radius);
      ppz_ff <= bfe_pkg::mul_parts(pr_ff, pr_ff);
      z3_ff <= prod3[127:72];
      // first horner add
      t4_ff <= add4.value;
      z4_ff <= z3_ff;
      sat4_ff <= use_lin & add4.sat;
      pp5_ff <= bfe_pkg::mul_parts(t4_ff, {8'b0, z4_ff});
      z5_ff <= z4_ff;
      t5_ff <= t4_ff;
      sat5_ff <= sat4_ff;
      m6_ff <= msat6 ? {64{1'b1}} : prod6[95:32];
      z6_ff <= z5_ff;
      t6_ff <= t5_ff;
      sat6_ff <= sat5_ff | (use_quad & msat6);
      u7_ff <= add7.value;
      z7_ff <= z6_ff;
      t7_ff <= t6_ff;
      sat7_ff <= sat6_ff | (use_quad & add7.sat);
      pp8_ff <= bfe_pkg::mul_parts(u7_ff, {8'b0, z7_ff});
      u8_ff <= u7_ff;
      t8_ff <= t7_ff;
      sat8_ff <= sat7_ff;
      m9_ff <= msat9 ? {64{1'b1}} : prod9[95:32];
      u9_ff <= u8_ff;
      t9_ff <= t8_ff;
      sat9_ff <= sat8_ff | (use_cub & msat9);
      f_ff <= f_in;
      sat_ff <= sat10_in;
   end

   assign out_valid = valid_ff[9];
   assign poly_value = f_ff;
   assign poly_sat = sat_ff;

endmodule

// ----- hdl/bfe_divider.sv -----
// pipelined restoring divider, one quotient bit per stage, with overflow clamp
module bfe_divider #(
   parameter int FRAC_BITS_OUT = bfe_pkg::FRAC_BITS_OUT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [63:0] num,
   input  logic [63:0] den,
   input  logic        in_sat,
   output logic        out_valid,
   output logic [47:0] quotient,
   output logic        out_sat
);

   localparam int SH = bfe_pkg::OUT_W - FRAC_BITS_OUT;
   localparam int STEPS = bfe_pkg::OUT_W;

   logic [95:0] den_sh;
   logic [111:0] d_wide;
   logic over;

   logic        v0_ff, sat0_ff, ov0_ff;
   logic [63:0] r0_ff, den0_ff;
   logic [47:0] dl0_ff;

   logic        v_ff [0:STEPS-1];
   logic        sat_ff [0:STEPS-1];
   logic        ov_ff [0:STEPS-1];
   logic [63:0] r_ff [0:STEPS-1];
   logic [63:0] den_ff [0:STEPS-1];
   logic [47:0] dl_ff [0:STEPS-1];
   logic [47:0] q_ff [0:STEPS-1];

   assign den_sh = {32'b0, den} << SH;
   assign over = {32'b0, num} >= den_sh;
   assign d_wide = {48'b0, num} << FRAC_BITS_OUT;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      sat0_ff <= in_sat;
      ov0_ff <= over;
      r0_ff <= d_wide[111:48];
      den0_ff <= den;
      dl0_ff <= d_wide[47:0];
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic        vs, ss, os;
      logic [63:0] rs, ds;
      logic [47:0] ls, qs;
      logic [64:0] trial;
      logic        ge;
      logic [64:0] diff;

      if (k == 0) begin : g_first
         assign vs = v0_ff;
         assign ss = sat0_ff;
         assign os = ov0_ff;
         assign rs = r0_ff;
         assign ds = den0_ff;
         assign ls = dl0_ff;
         assign qs = '0;
      end else begin : g_next
         assign vs = v_ff[k-1];
         assign ss = sat_ff[k-1];
         assign os = ov_ff[k-1];
         assign rs = r_ff[k-1];
         assign ds = den_ff[k-1];
         assign ls = dl_ff[k-1];
         assign qs = q_ff[k-1];
      end

      assign trial = {rs, ls[47]};
      assign ge = trial >= {1'b0, ds};
      assign diff = trial - {1'b0, ds};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= vs;
         end
      end

      always_ff @(posedge clock) begin
         sat_ff[k] <= ss;
         ov_ff[k] <= os;
         r_ff[k] <= ge ? diff[63:0] : trial[63:0];
         den_ff[k] <= ds;
         dl_ff[k] <= {ls[46:0], 1'b0};
         q_ff[k] <= {qs[46:0], ge};
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign quotient = ov_ff[STEPS-1] ? bfe_pkg::OUT_MASK : q_ff[STEPS-1];
   assign out_sat = sat_ff[STEPS-1] | ov_ff[STEPS-1];

endmodule

// ----- hdl/bfe_sqrt.sv -----
// pipelined digit-by-digit square root, one root bit per stage
module bfe_sqrt #(
   parameter int FRAC_BITS_OUT = bfe_pkg::FRAC_BITS_OUT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  logic [47:0] value,
   input  logic        in_sat,
   output logic        out_valid,
   output logic [47:0] value_out,
   output logic [47:0] root,
   output logic        out_sat
);

   localparam int STEPS = bfe_pkg::ROOT_W;
   localparam int NW = 2 * STEPS;

   logic [NW-1:0] radicand;

   logic          v_ff [0:STEPS-1];
   logic          sat_ff [0:STEPS-1];
   logic [47:0]   fs_ff [0:STEPS-1];
   logic [NW-1:0] n_ff [0:STEPS-1];
   logic [49:0]   r_ff [0:STEPS-1];
   logic [47:0]   q_ff [0:STEPS-1];

   assign radicand = {48'b0, value} << FRAC_BITS_OUT;

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic          vs, ss;
      logic [47:0]   fss, qs;
      logic [NW-1:0] ns;
      logic [49:0]   rs;
      logic [51:0]   rem;
      logic [51:0]   trial;
      logic          ge;
      logic [51:0]   diff;

      if (k == 0) begin : g_first
         assign vs = in_valid;
         assign ss = in_sat;
         assign fss = value;
         assign ns = radicand;
         assign rs = '0;
         assign qs = '0;
      end else begin : g_next
         assign vs = v_ff[k-1];
         assign ss = sat_ff[k-1];
         assign fss = fs_ff[k-1];
         assign ns = n_ff[k-1];
         assign rs = r_ff[k-1];
         assign qs = q_ff[k-1];
      end

      // bring down two radicand bits, try root bit one
      assign rem = {rs, ns[NW-1:NW-2]};
      assign trial = {2'b0, qs, 2'b01};
      assign ge = rem >= trial;
      assign diff = rem - trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= vs;
         end
      end

      always_ff @(posedge clock) begin
         sat_ff[k] <= ss;
         fs_ff[k] <= fss;
         n_ff[k] <= {ns[NW-3:0], 2'b00};
         r_ff[k] <= ge ? diff[49:0] : rem[49:0];
         q_ff[k] <= {qs[46:0], ge};
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign value_out = fs_ff[STEPS-1];
   assign root = q_ff[STEPS-1];
   assign out_sat = sat_ff[STEPS-1];

endmodule

// ----- hdl/barrier_factor_eval_top.sv -----
// barrier factor evaluator: top level with configuration registers
// Takes one momentum sample per clock (busy never rises) and returns each result
// after 10 stages of z and polynomial evaluation, 49 stages of the one-bit-per-stage
// divider and 48 stages of the one-bit-per-stage square root. The numerator
// polynomial is recomputed from the reference momentum in a second lane alongside
// each sample. rsp_valid is high for one cycle per result and results cannot be
// held off. Configuration writes take effect at once and must be made while no
// transaction is in flight.
module barrier_factor_eval_top #(
   parameter int FRAC_BITS_OUT = bfe_pkg::FRAC_BITS_OUT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_momentum,
   output logic        rsp_valid,
   output logic [47:0] rsp_factor_squared,
   output logic [47:0] rsp_factor,
   output logic        rsp_saturated,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [2:0]  spin_ff;
   logic [31:0] radius_ff;
   logic [31:0] ref_momentum_ff;

   logic        accept;
   logic        num_valid, den_valid;
   logic [63:0] num_value, den_value;
   logic        num_sat, den_sat;
   logic        div_valid, div_sat;
   logic [47:0] div_q;

   assign busy = 1'b0;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         spin_ff <= 3'd0;
         radius_ff <= bfe_pkg::RADIUS_RESET;
         ref_momentum_ff <= 32'd0;
      end else if (csr_we) begin
         case (csr_index)
            bfe_pkg::CSR_SPIN: spin_ff <= csr_wdata[2:0];
            bfe_pkg::CSR_RADIUS: radius_ff <= csr_wdata;
            bfe_pkg::CSR_REF_MOMENTUM: ref_momentum_ff <= csr_wdata;
            default: spin_ff <= spin_ff;
         endcase
      end
   end

   bfe_poly_lane u_num_lane (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .momentum   (ref_momentum_ff),
      .radius     (radius_ff),
      .spin       (spin_ff),
      .out_valid  (num_valid),
      .poly_value (num_value),
      .poly_sat   (num_sat)
   );

   bfe_poly_lane u_den_lane (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .momentum   (req_momentum),
      .radius     (radius_ff),
      .spin       (spin_ff),
      .out_valid  (den_valid),
      .poly_value (den_value),
      .poly_sat   (den_sat)
   );

   bfe_divider #(
      .FRAC_BITS_OUT (FRAC_BITS_OUT)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (den_valid & num_valid),
      .num       (num_value),
      .den       (den_value),
      .in_sat    (num_sat | den_sat),
      .out_valid (div_valid),
      .quotient  (div_q),
      .out_sat   (div_sat)
   );

   bfe_sqrt #(
      .FRAC_BITS_OUT (FRAC_BITS_OUT)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .value     (div_q),
      .in_sat    (div_sat),
      .out_valid (rsp_valid),
      .value_out (rsp_factor_squared),
      .root      (rsp_factor),
      .out_sat   (rsp_saturated)
   );

endmodule

// ----- hdl/barrier_factor_eval_checker.sv -----
// port-level checker for the barrier factor evaluator and its bind
`include "barrier_factor_eval_top_assert.svh"

module barrier_factor_eval_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [47:0] rsp_factor_squared,
   input logic [47:0] rsp_factor
);

   // every transaction comes back after the fixed latency
   `BFE_ASSERT_IMP(a_latency, clock, reset, start && !busy, ##(bfe_pkg::LATENCY) rsp_valid, "result missing after fixed latency")

   // no result without a transaction at the matching cycle
   `BFE_ASSERT_IMP(a_no_phantom, clock, reset, rsp_valid, $past(start && !busy, bfe_pkg::LATENCY), "result without a transaction")

   `BFE_ASSERT_IMP(a_zero_root, clock, reset, rsp_valid && rsp_factor_squared == 48'd0, rsp_factor == 48'd0, "nonzero root of zero")

   `BFE_ASSERT_ALWAYS(a_never_busy, clock, reset, !busy, "busy raised on a streaming block")

endmodule

bind barrier_factor_eval_top barrier_factor_eval_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_factor_squared (rsp_factor_squared),
   .rsp_factor         (rsp_factor)
);
